// ----- src/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property after reset has been released.
`define QS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define QS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/qslerp_pkg.sv -----
// Shared constants, cell payload types and the arctangent table for the slerp unit.
package qslerp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 31;
    localparam int DIV_STEPS    = 31;

    localparam logic [14:0]        THR_RESET = 15'd16368;
    localparam logic [16:0]        T_ONE     = 17'd65536;
    localparam logic [30:0]        ONE_Q30   = 31'h4000_0000;
    localparam logic signed [34:0] GAIN_INV  = 35'sd652032874;

    typedef struct packed {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic signed [32:0] z;
    } cordic_t;

    typedef struct packed {
        logic [60:0] rem;
        logic [30:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [30:0] q;
        logic [30:0] den;
        logic        neg;
        logic        ovf;
    } div_t;

    typedef struct packed {
        logic [3:0][16:0] a;
        logic [3:0][15:0] b;
        logic [16:0]      t;
        logic             lin;
        logic [30:0]      c;
        logic [30:0]      s;
    } side_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            5'd24:   v = 30'd64;
            5'd25:   v = 30'd32;
            5'd26:   v = 30'd16;
            5'd27:   v = 30'd8;
            5'd28:   v = 30'd4;
            5'd29:   v = 30'd2;
            5'd30:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/qslerp_sqrt_cell.sv -----
// One result bit of the pipelined integer square root.
module qslerp_sqrt_cell (
    input  logic                clk,
    input  logic                en,
    input  logic [4:0]          step,
    input  qslerp_pkg::sqrt_t   d_in,
    output qslerp_pkg::sqrt_t   d_out
);

    qslerp_pkg::sqrt_t d_reg;
    qslerp_pkg::sqrt_t d_next;
    logic [63:0]       trial;
    logic [63:0]       rem_ext;
    logic [5:0]        sh_hi;
    logic [5:0]        sh_lo;

    always_comb
    begin
        sh_hi   = {1'b0, step} + 6'd1;
        sh_lo   = {step, 1'b0};
        rem_ext = {3'd0, d_in.rem};
        trial   = ({33'd0, d_in.root} << sh_hi) + (64'd1 << sh_lo);
        d_next  = d_in;
        if (rem_ext >= trial)
        begin
            d_next.rem  = 61'(rem_ext - trial);
            d_next.root = d_in.root | (31'd1 << step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ----- src/qslerp_cordic_cell.sv -----
// One micro-rotation of a CORDIC chain, vectoring or rotation mode.
module qslerp_cordic_cell (
    input  logic                clk,
    input  logic                en,
    input  logic                vec,
    input  logic [4:0]          step,
    input  logic [29:0]         angle,
    input  qslerp_pkg::cordic_t d_in,
    output qslerp_pkg::cordic_t d_out
);

    qslerp_pkg::cordic_t d_reg;
    qslerp_pkg::cordic_t d_next;
    logic signed [34:0]  dx;
    logic signed [34:0]  dy;
    logic signed [32:0]  at;
    logic                up;

    always_comb
    begin
        dx = $signed(d_in.y) >>> step;
        dy = $signed(d_in.x) >>> step;
        at = $signed({3'd0, angle});
        up = vec ? !($signed(d_in.y) > 35'sd0) : ($signed(d_in.z) >= 33'sd0);
        if (up)
        begin
            d_next.x = $signed(d_in.x) - dx;
            d_next.y = $signed(d_in.y) + dy;
            d_next.z = $signed(d_in.z) - at;
        end
        else
        begin
            d_next.x = $signed(d_in.x) + dx;
            d_next.y = $signed(d_in.y) - dy;
            d_next.z = $signed(d_in.z) + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ----- src/qslerp_div_cell.sv -----
// One quotient bit of the pipelined restoring divider.
module qslerp_div_cell (
    input  logic              clk,
    input  logic              en,
    input  logic [4:0]        step,
    input  qslerp_pkg::div_t  d_in,
    output qslerp_pkg::div_t  d_out
);

    qslerp_pkg::div_t d_reg;
    qslerp_pkg::div_t d_next;
    logic [63:0]      sub;

    always_comb
    begin
        sub    = {33'd0, d_in.den} << step;
        d_next = d_in;
        if (d_in.rem >= sub)
        begin
            d_next.rem = d_in.rem - sub;
            d_next.q   = d_in.q | (31'd1 << step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ----- src/quaternion_slerp_unit.sv -----
// Throughput: one item per cycle while the skid register is empty; the depth is set by the 31-cell square root,
// the 16-cell atan2 chain, the two 16-cell sine chains and the two 31-cell dividers.
// Stall: the whole chain holds while the output skid register is occupied.
// Reset: clears all valid flags and loads near_threshold with 16368; no clearing pass.
module quaternion_slerp_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [14:0]  cfg_wdata,      // near_threshold
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [151:0] s_axis_tdata,   // a_w a_x a_y a_z b_w b_x b_y b_z t_frac, 7'b0
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata    // r_w r_x r_y r_z
);

    localparam int ST_DOT = 2;
    localparam int ST_RAD = 3;
    localparam int ST_SQN = ST_RAD + qslerp_pkg::SQRT_STEPS;
    localparam int ST_AT0 = ST_SQN + 1;
    localparam int ST_ATN = ST_SQN + qslerp_pkg::CORDIC_STEPS;
    localparam int ST_P   = ST_ATN + 1;
    localparam int ST_SNN = ST_P + qslerp_pkg::CORDIC_STEPS;
    localparam int ST_DP  = ST_SNN + 1;
    localparam int ST_DVN = ST_DP + qslerp_pkg::DIV_STEPS;
    localparam int ST_K   = ST_DVN + 1;
    localparam int ST_M   = ST_K + 1;
    localparam int ST_OUT = ST_M + 1;

    logic [14:0]                thr_reg;
    logic                       en;
    logic [ST_OUT:1]            vld_reg;
    qslerp_pkg::side_t          side_reg  [1:ST_M];
    qslerp_pkg::side_t          side_next [1:ST_M];
    logic signed [31:0]         pr_reg    [4];
    logic signed [31:0]         pr_next   [4];
    logic [60:0]                rad_reg;
    logic [61:0]                csq;
    logic signed [33:0]         dot;
    logic [33:0]                dabs;
    logic [30:0]                th;
    logic [47:0]                pm0;
    logic [47:0]                pm1;
    logic [30:0]                p0_reg;
    logic [30:0]                p1_reg;
    qslerp_pkg::div_t           dp0_reg;
    qslerp_pkg::div_t           dp1_reg;
    logic signed [31:0]         k0_reg;
    logic signed [31:0]         k1_reg;
    logic signed [31:0]         k0_next;
    logic signed [31:0]         k1_next;
    logic signed [48:0]         m_reg [4];
    logic signed [47:0]         n_reg [4];
    logic [63:0]                res_reg;
    logic [63:0]                res_next;
    logic [63:0]                out_reg;
    logic                       out_vld_reg;
    logic [63:0]                skid_reg;
    logic                       skid_vld_reg;
    logic                       take;
    qslerp_pkg::sqrt_t          sq  [0:qslerp_pkg::SQRT_STEPS];
    qslerp_pkg::cordic_t        atw [0:qslerp_pkg::CORDIC_STEPS];
    qslerp_pkg::cordic_t        sn0 [0:qslerp_pkg::CORDIC_STEPS];
    qslerp_pkg::cordic_t        sn1 [0:qslerp_pkg::CORDIC_STEPS];
    qslerp_pkg::div_t           dv0 [0:qslerp_pkg::DIV_STEPS];
    qslerp_pkg::div_t           dv1 [0:qslerp_pkg::DIV_STEPS];

    function automatic qslerp_pkg::div_t div_prep(input logic signed [34:0] y,
                                                  input logic [30:0] den);
        logic [34:0]      mag;
        qslerp_pkg::div_t d;
        mag   = y[34] ? 35'(-y) : y;
        d.rem = {mag[33:0], 30'd0};
        d.q   = 31'd0;
        d.den = den;
        d.neg = y[34];
        d.ovf = d.rem >= {2'd0, den, 31'd0};
        return d;
    endfunction

    function automatic logic signed [31:0] weight(input qslerp_pkg::div_t d);
        logic [30:0] mag;
        mag = (d.ovf || (d.q > qslerp_pkg::ONE_Q30)) ? qslerp_pkg::ONE_Q30 : d.q;
        return d.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;
    assign take          = out_vld_reg && m_axis_tready;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

    // side data line: operands, fraction, path flag, cosine and sine
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            side_next[1].a[i] = {s_axis_tdata[16*i+15], s_axis_tdata[16*i +: 16]};
            side_next[1].b[i] = s_axis_tdata[64+16*i +: 16];
            pr_next[i]        = $signed(s_axis_tdata[16*i +: 16])
                              * $signed(s_axis_tdata[64+16*i +: 16]);
        end
        side_next[1].t   = (s_axis_tdata[144:128] > qslerp_pkg::T_ONE) ?
                           qslerp_pkg::T_ONE : s_axis_tdata[144:128];
        side_next[1].lin = 1'b0;
        side_next[1].c   = 31'd0;
        side_next[1].s   = 31'd0;

        for (int k = 2; k <= ST_M; k++)
        begin
            side_next[k] = side_reg[k-1];
        end

        dot = 34'(pr_reg[0]) + 34'(pr_reg[1]) + 34'(pr_reg[2]) + 34'(pr_reg[3]);
        dabs = dot[33] ? 34'(-dot) : dot;
        if (dot[33])
        begin
            for (int i = 0; i < 4; i++)
            begin
                side_next[ST_DOT].a[i] = 17'(-$signed(side_reg[ST_DOT-1].a[i]));
            end
        end
        side_next[ST_DOT].lin = dabs > {5'd0, thr_reg, 14'd0};
        side_next[ST_DOT].c   = (dabs > 34'h1000_0000) ? qslerp_pkg::ONE_Q30 :
                                {dabs[28:0], 2'b00};

        side_next[ST_AT0].s   = sq[qslerp_pkg::SQRT_STEPS].root;
        side_next[ST_AT0].lin = side_reg[ST_AT0-1].lin ||
                                (sq[qslerp_pkg::SQRT_STEPS].root == 31'd0);
    end

    assign csq = side_reg[ST_DOT].c * side_reg[ST_DOT].c;

    assign sq[0]  = '{rem: rad_reg, root: 31'd0};
    assign atw[0] = '{x: $signed({4'd0, side_reg[ST_SQN].c}),
                      y: $signed({4'd0, sq[qslerp_pkg::SQRT_STEPS].root}),
                      z: 33'sd0};
    assign sn0[0] = '{x: qslerp_pkg::GAIN_INV, y: 35'sd0, z: $signed({2'd0, p0_reg})};
    assign sn1[0] = '{x: qslerp_pkg::GAIN_INV, y: 35'sd0, z: $signed({2'd0, p1_reg})};
    assign dv0[0] = dp0_reg;
    assign dv1[0] = dp1_reg;

    assign th  = atw[qslerp_pkg::CORDIC_STEPS].z[32] ? 31'd0 :
                 atw[qslerp_pkg::CORDIC_STEPS].z[30:0];
    assign pm1 = th * side_reg[ST_ATN].t;
    assign pm0 = th * (qslerp_pkg::T_ONE - side_reg[ST_ATN].t);

    always_comb
    begin
        if (side_reg[ST_DVN].lin)
        begin
            k0_next = $signed({1'b0, qslerp_pkg::T_ONE - side_reg[ST_DVN].t, 14'd0});
            k1_next = $signed({1'b0, side_reg[ST_DVN].t, 14'd0});
        end
        else
        begin
            k0_next = weight(dv0[qslerp_pkg::DIV_STEPS]);
            k1_next = weight(dv1[qslerp_pkg::DIV_STEPS]);
        end
    end

    always_comb
    begin
        logic signed [49:0] acc;
        logic signed [19:0] rsh;
        res_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            acc = 50'(m_reg[i]) + 50'(n_reg[i]) + 50'sd536870912;
            rsh = acc[49:30];
            if (rsh > 20'sd32767)
            begin
                res_next[16*i +: 16] = 16'h7FFF;
            end
            else if (rsh < -20'sd32768)
            begin
                res_next[16*i +: 16] = 16'h8000;
            end
            else
            begin
                res_next[16*i +: 16] = rsh[15:0];
            end
        end
    end

    genvar j;
    generate
        for (j = 0; j < qslerp_pkg::SQRT_STEPS; j++)
        begin : g_sqrt
            qslerp_sqrt_cell u_cell (
                .clk   (clk),
                .en    (en),
                .step  (5'(qslerp_pkg::SQRT_STEPS - 1 - j)),
                .d_in  (sq[j]),
                .d_out (sq[j+1])
            );
        end
        for (j = 0; j < qslerp_pkg::CORDIC_STEPS; j++)
        begin : g_cordic
            qslerp_cordic_cell u_atan (
                .clk   (clk),
                .en    (en),
                .vec   (1'b1),
                .step  (5'(j)),
                .angle (qslerp_pkg::atan_q30(5'(j))),
                .d_in  (atw[j]),
                .d_out (atw[j+1])
            );
            qslerp_cordic_cell u_sin0 (
                .clk   (clk),
                .en    (en),
                .vec   (1'b0),
                .step  (5'(j)),
                .angle (qslerp_pkg::atan_q30(5'(j))),
                .d_in  (sn0[j]),
                .d_out (sn0[j+1])
            );
            qslerp_cordic_cell u_sin1 (
                .clk   (clk),
                .en    (en),
                .vec   (1'b0),
                .step  (5'(j)),
                .angle (qslerp_pkg::atan_q30(5'(j))),
                .d_in  (sn1[j]),
                .d_out (sn1[j+1])
            );
        end
        for (j = 0; j < qslerp_pkg::DIV_STEPS; j++)
        begin : g_div
            qslerp_div_cell u_div0 (
                .clk   (clk),
                .en    (en),
                .step  (5'(qslerp_pkg::DIV_STEPS - 1 - j)),
                .d_in  (dv0[j]),
                .d_out (dv0[j+1])
            );
            qslerp_div_cell u_div1 (
                .clk   (clk),
                .en    (en),
                .step  (5'(qslerp_pkg::DIV_STEPS - 1 - j)),
                .d_in  (dv1[j]),
                .d_out (dv1[j+1])
            );
        end
    endgenerate

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= ST_M; k++)
            begin
                side_reg[k] <= side_next[k];
            end
            pr_reg  <= pr_next;
            rad_reg <= 61'(62'h1000_0000_0000_0000 - csq);
            p0_reg  <= pm0[46:16];
            p1_reg  <= pm1[46:16];
            dp0_reg <= div_prep(sn0[qslerp_pkg::CORDIC_STEPS].y, side_reg[ST_SNN].s);
            dp1_reg <= div_prep(sn1[qslerp_pkg::CORDIC_STEPS].y, side_reg[ST_SNN].s);
            k0_reg  <= k0_next;
            k1_reg  <= k1_next;
            for (int i = 0; i < 4; i++)
            begin
                m_reg[i] <= $signed(side_reg[ST_K].a[i]) * k0_reg;
                n_reg[i] <= $signed(side_reg[ST_K].b[i]) * k1_reg;
            end
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= qslerp_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ST_OUT-1:1], s_axis_tvalid};
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (take)
            begin
                out_reg      <= skid_reg;
                skid_vld_reg <= 1'b0;
            end
        end
        else if (vld_reg[ST_OUT])
        begin
            if (!out_vld_reg || take)
            begin
                out_reg     <= res_reg;
                out_vld_reg <= 1'b1;
            end
            else
            begin
                skid_reg     <= res_reg;
                skid_vld_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_vld_reg <= 1'b0;
        end
    end

endmodule

// ----- src/qslerp_checker.sv -----
// Port-level checks for the slerp unit, bound to the top level.
`include "assert_macros.svh"

module qslerp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    `QS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result item dropped while stalled")
    `QS_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result item changed while stalled")
    `QS_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !m_axis_tvalid && s_axis_tready, "output valid or input blocked in reset")
    `QS_ASSERT(a_block_needs_out, !s_axis_tready |-> m_axis_tvalid, "input blocked with no result waiting")
    `QS_ASSERT(a_block_cause, $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready), "input blocked without an output stall")

endmodule

bind quaternion_slerp_unit qslerp_checker u_qslerp_checker (.*);

// ----- bench/testbench.sv -----
// Self-checking bench for the quaternion slerp unit: random and corner quaternions vs. an in-bench predictor.
module testbench;

    typedef struct {
        logic signed [15:0] a [4];
        logic signed [15:0] b [4];
        logic [16:0]        t;
    } slerp_item_t;

    class slerp_scoreboard;
        logic [63:0] pending_quats [$];
        logic [14:0] threshold;
        int          errors;
        int          checked;
        longint      atan_steps [16];

        function new();
            threshold = qslerp_pkg::THR_RESET;
            errors = 0;
            checked = 0;
            atan_steps = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                           16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                           131072, 65536, 32768};
        endfunction

        function longint unsigned root64(longint unsigned v);
            longint unsigned r;
            longint unsigned bitv;
            r = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= r + bitv)
                begin
                    v = v - (r + bitv);
                    r = (r >> 1) + bitv;
                end
                else
                    r = r >> 1;
                bitv = bitv >> 2;
            end
            return r;
        endfunction

        function longint rotate_sin(longint ang);
            longint x, y, z, dx, dy;
            x = 652032874;
            y = 0;
            z = ang;
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= atan_steps[i];
                end
                else
                begin
                    x += dx; y -= dy; z += atan_steps[i];
                end
            end
            return y;
        endfunction

        function longint vector_angle(longint y, longint x);
            longint z, dx, dy;
            z = 0;
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x += dx; y -= dy; z += atan_steps[i];
                end
                else
                begin
                    x -= dx; y += dy; z -= atan_steps[i];
                end
            end
            return z;
        endfunction

        function longint clamp_one(longint k);
            if (k > 64'sd1073741824)
                return 64'sd1073741824;
            if (k < -64'sd1073741824)
                return -64'sd1073741824;
            return k;
        endfunction

        function logic [63:0] interpolate(slerp_item_t it);
            longint a [4];
            longint b [4];
            longint dot, k0, k1, c, th, p0, p1, acc;
            longint unsigned s, t;
            logic linear;
            logic [63:0] res;
            dot = 0;
            k0 = 0;
            k1 = 0;
            for (int i = 0; i < 4; i++)
            begin
                a[i] = longint'(it.a[i]) * 65536;
                b[i] = longint'(it.b[i]) * 65536;
                dot += (a[i] * b[i]) >>> 32;
            end
            if (dot < 0)
            begin
                for (int i = 0; i < 4; i++)
                    a[i] = -a[i];
                dot = -dot;
            end
            t = it.t;
            if (t > 65536)
                t = 65536;
            linear = dot > (longint'(threshold) << 14);
            if (!linear)
            begin
                c = dot * 4;
                if (c > 64'sd1073741824)
                    c = 64'sd1073741824;
                s = root64((64'd1 << 60) - longint'(c) * longint'(c));
                if (s == 0)
                    linear = 1;
                else
                begin
                    th = vector_angle(longint'(s), c);
                    if (th < 0)
                        th = 0;
                    p1 = longint'((longint'(th) * t) >> 16);
                    p0 = longint'((longint'(th) * (65536 - t)) >> 16);
                    k0 = clamp_one(rotate_sin(p0) * 64'sd1073741824 / longint'(s));
                    k1 = clamp_one(rotate_sin(p1) * 64'sd1073741824 / longint'(s));
                end
            end
            if (linear)
            begin
                k0 = longint'((65536 - t) << 14);
                k1 = longint'(t << 14);
            end
            for (int i = 0; i < 4; i++)
            begin
                acc = a[i] * k0 + b[i] * k1;
                acc = (acc + (64'sd1 << 45)) >>> 46;
                if (acc > 32767)
                    acc = 32767;
                if (acc < -32768)
                    acc = -32768;
                res[i*16 +: 16] = acc[15:0];
            end
            return res;
        endfunction

        function void note_input(slerp_item_t it);
            pending_quats.push_back(interpolate(it));
        endfunction

        function void check_result(logic [63:0] got);
            logic [63:0] want;
            string names [4];
            names = '{"r_w", "r_x", "r_y", "r_z"};
            if (pending_quats.size() == 0)
            begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            want = pending_quats.pop_front();
            checked++;
            for (int i = 0; i < 4; i++)
                if (got[i*16 +: 16] !== want[i*16 +: 16])
                begin
                    $error("%s: expected %0d, actual %0d", names[i],
                           $signed(want[i*16 +: 16]), $signed(got[i*16 +: 16]));
                    errors++;
                end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [14:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;

    slerp_scoreboard quat_board;
    slerp_item_t     item_by_tdata;
    int              send_idle_pct;
    int              recv_idle_pct;
    logic            hold_go;
    logic            hold_done;
    int              hold_cnt;
    int              cycles;
    int              sent;
    int              phase_count;

    quaternion_slerp_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic slerp_item_t unpack_item(logic [151:0] d);
        slerp_item_t it;
        for (int i = 0; i < 4; i++)
        begin
            it.a[i] = d[i*16 +: 16];
            it.b[i] = d[64 + i*16 +: 16];
        end
        it.t = d[144:128];
        return it;
    endfunction

    function automatic logic [151:0] pack_item(slerp_item_t it);
        logic [151:0] d;
        d = '0;
        for (int i = 0; i < 4; i++)
        begin
            d[i*16 +: 16] = it.a[i];
            d[64 + i*16 +: 16] = it.b[i];
        end
        d[144:128] = it.t;
        return d;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            quat_board.note_input(unpack_item(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
            quat_board.check_result(m_axis_tdata);
    end

    // receiver: random stall, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_cnt <= 400;
            m_axis_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(slerp_item_t it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_item(it);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (quat_board.pending_quats.size() != 0)
            @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    task automatic write_threshold(logic [14:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        quat_board.threshold = v;
        @(posedge clk);
    endtask

    function automatic slerp_item_t make_item(int sel, int ap, int bp, logic [16:0] t);
        slerp_item_t it;
        for (int i = 0; i < 4; i++)
        begin
            it.a[i] = 16'(ap);
            it.b[i] = (i == sel) ? 16'(bp) : 16'sd0;
        end
        it.t = t;
        return it;
    endfunction

    function automatic slerp_item_t random_item();
        slerp_item_t it;
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 4; i++)
        begin
            if (kind < 3)
            begin
                it.a[i] = 16'($urandom);
                it.b[i] = 16'($urandom);
            end
            else
            begin
                it.a[i] = 16'($urandom_range(16384) - 8192);
                if (kind < 6)
                    it.b[i] = 16'($urandom_range(16384) - 8192);
                else
                    it.b[i] = 16'(it.a[i] + $urandom_range(128) - 64);
            end
            if (kind == 9)
                it.b[i] = -it.b[i];
        end
        it.t = ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        return it;
    endfunction

    initial
    begin
        slerp_item_t d;
        logic [14:0] settings [4];
        quat_board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        hold_go = 1'b0;
        cycles = 0;
        sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_item(0, -32768, -32768, 17'd0));
        send_item(make_item(0, 32767, 32767, 17'd65536));
        send_item(make_item(0, -32768, 32767, 17'd131071));
        send_item(make_item(0, 32767, -32768, 17'd32768));
        send_item(make_item(0, 0, 0, 17'd12345));
        d.a = '{16384, 0, 0, 0};
        d.b = '{16384, 0, 0, 0};
        d.t = 17'd20000;
        send_item(d);
        d.b = '{-16384, 0, 0, 0};
        send_item(d);
        d.b = '{0, 16384, 0, 0};
        send_item(d);
        d.t = 17'd0;
        send_item(d);
        d.t = 17'd65536;
        send_item(d);
        d.b = '{11585, 11585, 0, 0};
        d.t = 17'd98304;
        send_item(d);
        d.b = '{16380, 300, 0, 0};
        d.t = 17'd40000;
        send_item(d);
        d.a = '{16384, 16384, 0, 0};
        d.b = '{16384, 16384, 0, 0};
        send_item(d);
        d.b = '{-16384, 16384, 0, 0};
        send_item(d);
        d.a = '{-1, 1, -1, 1};
        d.b = '{21845, -21846, 10922, -10923};
        d.t = 17'd65535;
        send_item(d);
        drain();

        write_threshold(15'd32767);
        d.a = '{20000, 0, 0, 0};
        d.b = '{20000, 0, 0, 0};
        d.t = 17'd30000;
        send_item(d);
        d.b = '{-20000, 0, 0, 0};
        send_item(d);
        drain();

        settings = '{15'd0, 15'd32767, 15'd16384, 15'($urandom)};
        for (int p = 0; p < 4; p++)
        begin
            write_threshold(settings[p]);
            send_idle_pct = (p == 0) ? 36 : (p == 1) ? 70 : 0;
            recv_idle_pct = (p == 0) ? 70 : (p == 1) ? 36 : 0;
            for (int n = 0; n < 460; n++)
            begin
                if (p == 2 && n == 50)
                    hold_go <= 1'b1;
                send_item(random_item());
            end
            drain();
        end

        $display("Sent %0d items, checked %0d results over 6 threshold settings,",
                 sent, quat_board.checked);
        $display("with sender/receiver gaps, one long output hold-off and corner vectors.");
        if (quat_board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
